FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers for the scheduler core
// Clocked assertions with and without a reset qualifier; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define EDFTS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define EDFTS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define EDFTS_ASSERT(lbl, clk, rst, prop, msg)

`define EDFTS_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/core/edfts_pkg.sv
// ----------------------------------------------------------------------------
// edfts_pkg: shared types and codes of the EDF tick scheduler
// Input mode codes, register indexes and the controller/datapath buses.
// ----------------------------------------------------------------------------
package edfts_pkg;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int COUNT_BITS    = 4;
  localparam int STOP_BITS     = 16;
  localparam int SLOT_BITS     = 3;
  localparam int MASK_BITS     = 8;
  localparam int TICK_BITS     = 16;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TASK_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_TIME  = 2'd1;

  typedef struct packed {
    logic load_wr;
    logic tick_start;
    logic rd_issue;
    logic div_start;
    logic eval;
    logic dec_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic stop_hit;
    logic scan_end;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/edfts_rem.sv
// ----------------------------------------------------------------------------
// edfts_rem: iterative remainder unit
// Restoring division, one dividend bit per cycle; yields dividend mod divisor.
// A zero divisor returns the dividend.
// ----------------------------------------------------------------------------
module edfts_rem #(
  parameter int TIME_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] dividend,
  input  logic [TIME_BITS-1:0] divisor,
  output logic                 busy,
  output logic [TIME_BITS-1:0] rem
);

  localparam int NW = $clog2(TIME_BITS + 1);

  logic [NW-1:0]        cnt;
  logic [TIME_BITS-1:0] dvd;
  logic [TIME_BITS:0]   shifted;
  logic [TIME_BITS:0]   diff;

  assign shifted = {rem, dvd[TIME_BITS-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      busy <= 1'b0;
    end else if (start) begin
      cnt  <= NW'(TIME_BITS);
      busy <= 1'b1;
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != NW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
    end else if (busy) begin
      dvd <= {dvd[TIME_BITS-2:0], 1'b0};
      if (shifted >= {1'b0, divisor}) begin
        rem <= diff[TIME_BITS-1:0];
      end else begin
        rem <= shifted[TIME_BITS-1:0];
      end
    end
  end

endmodule

FILE: rtl/core/edfts_ctrl.sv
// ----------------------------------------------------------------------------
// edfts_ctrl: scheduler sequencer
// Walks each tick through slot reads, remainder runs, evaluation and the
// final work decrement and result load; loads complete in the idle state.
// ----------------------------------------------------------------------------
module edfts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              mode,
  output logic              in_stall,
  input  edfts_pkg::sts_t   sts,
  output edfts_pkg::cmd_t   cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_START = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_EVAL  = 7'b0010000,
    ST_DEC   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (mode == edfts_pkg::MODE_LOAD) begin
            cmd.load_wr = 1'b1;
          end else if (!sts.stop_hit) begin
            cmd.tick_start = 1'b1;
            state_next     = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sts.scan_end) begin
          state_next = ST_DEC;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = ST_START;
        end
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_DEC: begin
        cmd.dec_wr = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/edfts_dpath.sv
// ----------------------------------------------------------------------------
// edfts_dpath: scheduler datapath
// Slot memories, remaining-work store, time counter, configuration
// registers, best-deadline tracking and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module edfts_dpath #(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  edfts_pkg::cmd_t                      cmd,
  output edfts_pkg::sts_t                      sts,
  input  logic [edfts_pkg::SLOT_BITS-1:0]      task_slot,
  input  logic [TIME_BITS-1:0]                 arrival,
  input  logic [TIME_BITS-1:0]                 work_units,
  input  logic [TIME_BITS-1:0]                 period_len,
  input  logic                                 cfg_we,
  input  logic [edfts_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [edfts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic                                 run_valid,
  output logic [edfts_pkg::SLOT_BITS-1:0]      run_slot,
  output logic [edfts_pkg::MASK_BITS-1:0]      miss_mask,
  output logic [edfts_pkg::TICK_BITS-1:0]      tick_time
);

  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  logic [TIME_BITS-1:0] arr_mem  [MAX_TASKS];
  logic [TIME_BITS-1:0] work_mem [MAX_TASKS];
  logic [TIME_BITS-1:0] per_mem  [MAX_TASKS];
  logic [TIME_BITS-1:0] rw_mem   [MAX_TASKS];
  logic [MAX_TASKS-1:0] rw_valid;

  logic [TIME_BITS-1:0] arr_rd;
  logic [TIME_BITS-1:0] work_rd;
  logic [TIME_BITS-1:0] per_rd;
  logic [TIME_BITS-1:0] rw_raw;
  logic                 rw_ok;
  logic [TIME_BITS-1:0] rw_rd;

  logic [TIME_BITS-1:0]              time_now;
  logic [edfts_pkg::COUNT_BITS-1:0]  task_count;
  logic [edfts_pkg::STOP_BITS-1:0]   stop_time;
  logic [CW-1:0]                     active_cnt;
  logic [CW-1:0]                     scan_idx;
  logic [SW-1:0]                     scan_addr;
  logic [SW-1:0]                     load_addr;
  logic                              load_ok;

  logic                              found;
  logic [SW-1:0]                     best_idx;
  logic [TIME_BITS:0]                best_left;
  logic [TIME_BITS-1:0]              best_rw;
  logic [edfts_pkg::MASK_BITS-1:0]   miss;
  logic [edfts_pkg::MASK_BITS-1:0]   miss_set;
  logic [31:0]                       best_wide;

  logic                 div_busy;
  logic [TIME_BITS-1:0] phase;
  logic [TIME_BITS:0]   per_ext;
  logic [TIME_BITS:0]   left;
  logic                 phase0;
  logic [TIME_BITS-1:0] rw_cur;
  logic                 cand;

  logic                 rw_we;
  logic [SW-1:0]        rw_waddr;
  logic [TIME_BITS-1:0] rw_wdata;

  edfts_rem #(
    .TIME_BITS (TIME_BITS)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (time_now),
    .divisor  (per_rd),
    .busy     (div_busy),
    .rem      (phase)
  );

  assign active_cnt = (32'(task_count) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(task_count);
  assign scan_addr  = scan_idx[SW-1:0];
  assign load_addr  = SW'(task_slot);
  assign load_ok    = (32'(task_slot) < MAX_TASKS);
  assign rw_rd      = rw_ok ? rw_raw : '0;
  assign best_wide  = 32'(best_idx);

  assign sts.stop_hit = (32'(time_now) >= 32'(stop_time));
  assign sts.scan_end = (scan_idx == active_cnt);
  assign sts.div_done = !div_busy;
  assign sts.out_free = !out_valid || !out_stall;

  always_comb begin
    per_ext = (per_rd == '0) ? {1'b1, {TIME_BITS{1'b0}}} : {1'b0, per_rd};
    left    = per_ext - {1'b0, phase};
    phase0  = (phase == '0);
    rw_cur  = phase0 ? work_rd : rw_rd;
    cand    = (rw_cur != '0) && (arr_rd <= time_now) && (!found || (left < best_left));
    for (int b = 0; b < edfts_pkg::MASK_BITS; b++) begin
      miss_set[b] = phase0 && (rw_rd != '0) && (time_now != '0) && (32'(scan_idx) == b);
    end
  end

  always_comb begin
    rw_we    = 1'b0;
    rw_waddr = scan_addr;
    rw_wdata = work_rd;
    if (cmd.eval && phase0) begin
      rw_we = 1'b1;
    end else if (cmd.dec_wr && found) begin
      rw_we    = 1'b1;
      rw_waddr = best_idx;
      rw_wdata = best_rw - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && load_ok) begin
      arr_mem[load_addr]  <= arrival;
      work_mem[load_addr] <= work_units;
      per_mem[load_addr]  <= period_len;
    end
    if (cmd.rd_issue) begin
      arr_rd  <= arr_mem[scan_addr];
      work_rd <= work_mem[scan_addr];
      per_rd  <= per_mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rw_we) begin
      rw_mem[rw_waddr] <= rw_wdata;
    end
    if (cmd.rd_issue) begin
      rw_raw <= rw_mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rw_valid   <= '0;
      rw_ok      <= 1'b0;
      time_now   <= '0;
      task_count <= '0;
      stop_time  <= '1;
      scan_idx   <= '0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (rw_we) begin
        rw_valid[rw_waddr] <= 1'b1;
      end
      if (cmd.rd_issue) begin
        rw_ok <= rw_valid[scan_addr];
      end
      if (cfg_we && (cfg_index == edfts_pkg::CFG_TASK_COUNT)) begin
        task_count <= cfg_data[edfts_pkg::COUNT_BITS-1:0];
      end
      if (cfg_we && (cfg_index == edfts_pkg::CFG_STOP_TIME)) begin
        stop_time <= cfg_data[edfts_pkg::STOP_BITS-1:0];
      end
      if (cmd.tick_start) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else if (cmd.eval) begin
        scan_idx <= scan_idx + 1'b1;
        if (cand) begin
          found <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        time_now  <= time_now + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      miss <= '0;
    end else if (cmd.eval) begin
      miss <= miss | miss_set;
      if (cand) begin
        best_idx  <= scan_addr;
        best_left <= left;
        best_rw   <= rw_cur;
      end
    end
    if (cmd.out_load) begin
      run_valid <= found;
      run_slot  <= found ? best_wide[edfts_pkg::SLOT_BITS-1:0] : '0;
      miss_mask <= miss;
      tick_time <= edfts_pkg::TICK_BITS'(time_now);
    end
  end

  `EDFTS_ASSERT(a_eval_in_range, clk, rst, cmd.eval |-> (scan_idx < active_cnt), "eval past active slots")
  `EDFTS_ASSERT(a_load_when_free, clk, rst, cmd.out_load |-> (!out_valid || !out_stall), "result overwritten")
  `EDFTS_ASSERT(a_dec_nonzero, clk, rst, (cmd.dec_wr && found) |-> (best_rw != '0), "work underflow")
  `EDFTS_ASSERT_NR(a_reset_clears_out, clk, rst |=> !out_valid, "result valid after reset")

endmodule

FILE: rtl/core/edf_tick_scheduler.sv
// ----------------------------------------------------------------------------
// edf_tick_scheduler: periodic earliest-deadline-first tick scheduler
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    mode task_slot arrival
//                                              work_units period_len
//   out      source     out_valid / out_stall  run_valid run_slot miss_mask
//                                              tick_time
//   cfg      sink       cfg_valid / cfg_ready  cfg_index cfg_data
//
// A load beat is written in the idle state. A tick beat runs the bit-serial
// remainder unit once per active slot. A tick at or past stop_time is taken
// and gives no beat.
// Reset is synchronous; no clearing pass is needed. cfg_ready is always high.
// A stalled result holds in the output register; the next beat is taken
// meanwhile and its result waits for the register to free.
// ----------------------------------------------------------------------------
module edf_tick_scheduler #(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 mode,
  input  logic [edfts_pkg::SLOT_BITS-1:0]      task_slot,
  input  logic [TIME_BITS-1:0]                 arrival,
  input  logic [TIME_BITS-1:0]                 work_units,
  input  logic [TIME_BITS-1:0]                 period_len,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 run_valid,
  output logic [edfts_pkg::SLOT_BITS-1:0]      run_slot,
  output logic [edfts_pkg::MASK_BITS-1:0]      miss_mask,
  output logic [edfts_pkg::TICK_BITS-1:0]      tick_time,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [edfts_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [edfts_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  edfts_pkg::cmd_t cmd;
  edfts_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  edfts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  edfts_dpath #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .task_slot  (task_slot),
    .arrival    (arrival),
    .work_units (work_units),
    .period_len (period_len),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .run_valid  (run_valid),
    .run_slot   (run_slot),
    .miss_mask  (miss_mask),
    .tick_time  (tick_time)
  );

endmodule

FILE: verif/tb_edf_tick_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edf_tick_scheduler: self-checking bench for the EDF tick scheduler
// Loads task slots and sends tick beats, with directed cases first and then
// random phases under varied register settings and random back-pressure.
// A scoreboard predicts every tick result and compares each result beat
// field by field.
// ----------------------------------------------------------------------------

localparam int MAX_SLOTS = 1 << edfts_pkg::SLOT_BITS;

typedef struct packed {
  logic                              mode;
  logic [edfts_pkg::SLOT_BITS-1:0]   slot;
  logic [edfts_pkg::TICK_BITS-1:0]   arrival;
  logic [edfts_pkg::TICK_BITS-1:0]   work;
  logic [edfts_pkg::TICK_BITS-1:0]   period;
} sched_beat_t;

typedef struct packed {
  logic                              run_valid;
  logic [edfts_pkg::SLOT_BITS-1:0]   run_slot;
  logic [edfts_pkg::MASK_BITS-1:0]   miss_mask;
  logic [edfts_pkg::TICK_BITS-1:0]   tick_time;
} tick_report_t;

class sched_scoreboard;
  logic [edfts_pkg::TICK_BITS-1:0]  slot_period  [MAX_SLOTS];
  logic [edfts_pkg::TICK_BITS-1:0]  slot_arrival [MAX_SLOTS];
  logic [edfts_pkg::TICK_BITS-1:0]  slot_work    [MAX_SLOTS];
  logic [edfts_pkg::TICK_BITS-1:0]  work_left    [MAX_SLOTS];
  logic [edfts_pkg::TICK_BITS-1:0]  now;
  logic [edfts_pkg::COUNT_BITS-1:0] task_count;
  logic [edfts_pkg::STOP_BITS-1:0]  stop_time;
  tick_report_t                     expected_runs [$];
  int                               errors;

  function new();
    errors = 0;
    now = '0;
    task_count = '0;
    stop_time = '1;
    for (int s = 0; s < MAX_SLOTS; s++) begin
      work_left[s] = '0;
    end
  endfunction

  function int pending();
    return expected_runs.size();
  endfunction

  function void write_reg(logic [edfts_pkg::CFG_IDX_BITS-1:0] idx,
                          logic [edfts_pkg::CFG_DATA_BITS-1:0] data);
    if (idx == edfts_pkg::CFG_TASK_COUNT) begin
      task_count = data[edfts_pkg::COUNT_BITS-1:0];
    end else if (idx == edfts_pkg::CFG_STOP_TIME) begin
      stop_time = data;
    end
  endfunction

  // returns 1 when the beat takes effect
  function bit note_beat(sched_beat_t b);
    tick_report_t rep;
    int unsigned  active;
    int unsigned  per;
    int unsigned  phase;
    int unsigned  left;
    int unsigned  best_left;
    bit           found;
    int           best;
    if (b.mode == edfts_pkg::MODE_LOAD) begin
      slot_arrival[b.slot] = b.arrival;
      slot_work[b.slot] = b.work;
      slot_period[b.slot] = b.period;
      return 1'b1;
    end
    if (now >= stop_time) return 1'b0;
    active = (task_count > MAX_SLOTS) ? MAX_SLOTS : task_count;
    rep = '0;
    found = 1'b0;
    best = 0;
    best_left = 0;
    for (int s = 0; s < active; s++) begin
      per = (slot_period[s] == 0) ? (32'd1 << edfts_pkg::TICK_BITS) : 32'(slot_period[s]);
      phase = now % per;
      left = per - phase;
      if (phase == 0) begin
        if (work_left[s] != 0 && now != 0) rep.miss_mask[s] = 1'b1;
        work_left[s] = slot_work[s];
      end
      if (work_left[s] != 0 && slot_arrival[s] <= now && (!found || left < best_left)) begin
        found = 1'b1;
        best = s;
        best_left = left;
      end
    end
    if (found) work_left[best] = work_left[best] - 1'b1;
    rep.run_valid = found;
    rep.run_slot = found ? edfts_pkg::SLOT_BITS'(best) : '0;
    rep.tick_time = now;
    expected_runs.push_back(rep);
    now = now + 1'b1;
    return 1'b1;
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_beat(logic rv, logic [edfts_pkg::SLOT_BITS-1:0] rs,
                           logic [edfts_pkg::MASK_BITS-1:0] mm,
                           logic [edfts_pkg::TICK_BITS-1:0] tt);
    tick_report_t want;
    if (expected_runs.size() == 0) begin
      $display("%0t: unexpected result beat: expected none actual %0h/%0h/%0h/%0h",
               $time, rv, rs, mm, tt);
      errors++;
      return;
    end
    want = expected_runs.pop_front();
    compare_field("run_valid", 16'(want.run_valid), 16'(rv));
    compare_field("run_slot", 16'(want.run_slot), 16'(rs));
    compare_field("miss_mask", 16'(want.miss_mask), 16'(mm));
    compare_field("tick_time", want.tick_time, tt);
  endfunction
endclass

module tb_edf_tick_scheduler;

  localparam int SETTLE_CYCLES  = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BEATS   = 1550;

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_stall;
  logic                                mode;
  logic [edfts_pkg::SLOT_BITS-1:0]     task_slot;
  logic [edfts_pkg::TICK_BITS-1:0]     arrival;
  logic [edfts_pkg::TICK_BITS-1:0]     work_units;
  logic [edfts_pkg::TICK_BITS-1:0]     period_len;
  logic                                out_valid;
  logic                                out_stall;
  logic                                run_valid;
  logic [edfts_pkg::SLOT_BITS-1:0]     run_slot;
  logic [edfts_pkg::MASK_BITS-1:0]     miss_mask;
  logic [edfts_pkg::TICK_BITS-1:0]     tick_time;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [edfts_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [edfts_pkg::CFG_DATA_BITS-1:0] cfg_data;

  sched_scoreboard sb;
  int              beats_sent;
  int              burst_left;
  int              quiet_cycles;
  bit              steady;
  bit              long_hold;

  edf_tick_scheduler dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .task_slot  (task_slot),
    .arrival    (arrival),
    .work_units (work_units),
    .period_len (period_len),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .run_valid  (run_valid),
    .run_slot   (run_slot),
    .miss_mask  (miss_mask),
    .tick_time  (tick_time),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic sched_beat_t load_beat(int slot, int arr, int work, int per);
    sched_beat_t b;
    b.mode = edfts_pkg::MODE_LOAD;
    b.slot = edfts_pkg::SLOT_BITS'(slot);
    b.arrival = 16'(arr);
    b.work = 16'(work);
    b.period = 16'(per);
    return b;
  endfunction

  function automatic sched_beat_t tick_beat();
    sched_beat_t b;
    b.mode = edfts_pkg::MODE_TICK;
    b.slot = edfts_pkg::SLOT_BITS'($urandom);
    b.arrival = 16'($urandom);
    b.work = 16'($urandom);
    b.period = 16'($urandom);
    return b;
  endfunction

  function automatic sched_beat_t shaped_load();
    sched_beat_t b;
    b = tick_beat();
    b.mode = edfts_pkg::MODE_LOAD;
    if ($urandom_range(0, 9) == 0) return b;
    if ($urandom_range(0, 3) == 0) b.arrival = sb.now + 16'($urandom_range(0, 12));
    else b.arrival = 16'($urandom_range(0, sb.now));
    b.work = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 20))
                                         : 16'($urandom_range(0, 4));
    case ($urandom_range(0, 15))
      0: b.period = '0;
      1, 2: b.period = 16'($urandom_range(17, 300));
      default: b.period = 16'($urandom_range(1, 16));
    endcase
    return b;
  endfunction

  task automatic send_beat(input sched_beat_t b);
    in_valid <= 1'b1;
    mode <= b.mode;
    task_slot <= b.slot;
    arrival <= b.arrival;
    work_units <= b.work;
    period_len <= b.period;
    do @(posedge clk); while (in_stall);
    void'(sb.note_beat(b));
    beats_sent++;
  endtask

  task automatic offer(input sched_beat_t b);
    if (!steady && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    send_beat(b);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [edfts_pkg::COUNT_BITS-1:0] count,
                              input logic [edfts_pkg::STOP_BITS-1:0] stop);
    logic [edfts_pkg::CFG_DATA_BITS-1:0] data;
    pause_until_drained();
    data = {12'($urandom), count};
    cfg_valid <= 1'b1;
    cfg_index <= edfts_pkg::CFG_TASK_COUNT;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(edfts_pkg::CFG_TASK_COUNT, data);
    cfg_index <= edfts_pkg::CFG_STOP_TIME;
    cfg_data <= stop;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(edfts_pkg::CFG_STOP_TIME, stop);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    steady = 1'b1;
    offer(load_beat(0, 0, 3, 4));
    offer(load_beat(1, 0, 16'hFFFF, 16'hFFFF));
    offer(load_beat(2, 0, 2, 0));
    offer(load_beat(3, 16'hFFFF, 1, 2));
    offer(load_beat(4, 2, 1, 3));
    offer(load_beat(5, 0, 5, 5));
    offer(load_beat(6, 0, 0, 1));
    offer(load_beat(7, 1, 2, 6));
    write_config(0, 0);
    offer(tick_beat());
    write_config(8, 16'hFFFF);
    repeat (12) offer(tick_beat());
    write_config(15, sb.now + 16'd2);
    offer(load_beat(5, 0, 16'hFFFF, 1));
    repeat (4) offer(tick_beat());
  endtask

  task automatic random_phase(input int phase_no);
    logic [edfts_pkg::COUNT_BITS-1:0] count;
    logic [edfts_pkg::STOP_BITS-1:0]  stop;
    int                               ticks;
    case ($urandom_range(0, 5))
      0: count = 0;
      1: count = 8;
      2: count = 15;
      3: count = 1;
      default: count = edfts_pkg::COUNT_BITS'($urandom);
    endcase
    case ($urandom_range(0, 15))
      0: stop = '0;
      1, 2: stop = 16'($urandom);
      3, 4, 5: stop = sb.now + 16'($urandom_range(0, 24));
      default: stop = '1;
    endcase
    if (phase_no == 3) begin
      count = 8;
      stop = '1;
    end
    write_config(count, stop);
    steady = ($urandom_range(0, 3) == 0);
    if (phase_no == 3) long_hold = 1'b1;
    repeat ($urandom_range(1, 4)) offer(shaped_load());
    ticks = $urandom_range(15, 50);
    repeat (ticks) begin
      if ($urandom_range(0, 11) == 0) offer(shaped_load());
      offer(tick_beat());
    end
  endtask

  // receiver back-pressure
  initial begin
    int stall_style;
    int style_left;
    out_stall <= 1'b0;
    stall_style = 0;
    style_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 300);
      end
      style_left--;
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_beat(run_valid, run_slot, miss_mask, tick_time);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int phase_no;
    sb = new();
    beats_sent = 0;
    burst_left = 0;
    steady = 1'b1;
    long_hold = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    mode <= edfts_pkg::MODE_LOAD;
    task_slot <= '0;
    arrival <= '0;
    work_units <= '0;
    period_len <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= edfts_pkg::CFG_TASK_COUNT;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    beats_sent = 0;
    phase_no = 0;
    while (beats_sent < RANDOM_BEATS) begin
      random_phase(phase_no);
      phase_no++;
    end
    pause_until_drained();
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
